// ===== hdl/gvps_pkg.sv =====
`default_nettype none

package gvps_pkg;

    // Command codes carried in the input tuser
    localparam logic [1:0] CMD_STEP  = 2'd0;
    localparam logic [1:0] CMD_ROT   = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;
    // unused code, ignored by the sequencer
    localparam logic [1:0] CMD_SPARE = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ON_TIME  = 1'b0;
    localparam logic CFG_ASSIGNED = 1'b1;

    // Phase codes as reported on the output
    localparam logic [1:0] PHASE_CODE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_CODE_DELAY = 2'd1;
    localparam logic [1:0] PHASE_CODE_OPEN  = 2'd2;
    localparam logic [1:0] PHASE_CODE_RUN   = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_DELAY = 4'b0010,
        PH_OPEN  = 4'b0100,
        PH_RUN   = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] mark_tick;
        logic [15:0] held_delay;
        logic        valve;
        logic        pending;
    } t_state;

    typedef struct packed {
        logic [15:0] on_time;
        logic        output_assigned;
    } t_cfg;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        unique case (ph)
            PH_IDLE:  code = PHASE_CODE_IDLE;
            PH_DELAY: code = PHASE_CODE_DELAY;
            PH_OPEN:  code = PHASE_CODE_OPEN;
            PH_RUN:   code = PHASE_CODE_RUN;
            default:  code = PHASE_CODE_IDLE;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/gvps_cfg.sv =====
`default_nettype none

module gvps_cfg (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic            i_cfg_index,
    input  wire logic [15:0]     i_cfg_data,
    output gvps_pkg::t_cfg       o_cfg
);

    gvps_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.on_time         <= 16'd0;
            r_cfg.output_assigned <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                gvps_pkg::CFG_ON_TIME:  r_cfg.on_time         <= i_cfg_data;
                gvps_pkg::CFG_ASSIGNED: r_cfg.output_assigned <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== hdl/gvps_step.sv =====
`default_nettype none

module gvps_step (
    input  wire gvps_pkg::t_state i_state,
    input  wire gvps_pkg::t_cfg   i_cfg,
    input  wire logic [1:0]      i_cmd,
    input  wire logic            i_gas,
    input  wire logic [15:0]     i_tick,
    input  wire logic [15:0]     i_delay,
    output gvps_pkg::t_state     o_state
);

    logic [15:0] w_elapsed;
    logic [15:0] w_held;

    // time since the mark, modulo 2^16
    assign w_elapsed = i_tick - i_state.mark_tick;
    // delay in force: leaving idle samples it fresh
    assign w_held    = (i_state.phase == gvps_pkg::PH_IDLE) ? i_delay : i_state.held_delay;

    always_comb begin
        o_state = i_state;
        case (i_cmd)
            gvps_pkg::CMD_STEP: begin
                if (i_cfg.output_assigned) begin
                    if (!i_gas) begin
                        o_state.valve     = 1'b0;
                        o_state.mark_tick = i_tick;
                        o_state.phase     = gvps_pkg::PH_IDLE;
                    end else if (i_state.phase == gvps_pkg::PH_RUN) begin
                        o_state.valve = 1'b1;
                    end else if (i_state.phase == gvps_pkg::PH_OPEN) begin
                        if (w_elapsed >= i_cfg.on_time) begin
                            o_state.valve = 1'b0;
                        end
                        o_state.pending = 1'b0;
                    end else begin
                        // idle or delaying
                        o_state.held_delay = w_held;
                        if (w_elapsed >= w_held) begin
                            // mark restarts now, so elapsed is zero here
                            o_state.valve     = (i_cfg.on_time != 16'd0);
                            o_state.mark_tick = i_tick;
                            o_state.phase     = gvps_pkg::PH_OPEN;
                            o_state.pending   = 1'b0;
                        end else begin
                            if (i_state.phase == gvps_pkg::PH_IDLE) begin
                                o_state.valve = 1'b0;
                            end
                            o_state.phase   = gvps_pkg::PH_DELAY;
                            o_state.pending = 1'b1;
                        end
                    end
                end
            end
            gvps_pkg::CMD_ROT: begin
                o_state.phase = gvps_pkg::PH_RUN;
            end
            gvps_pkg::CMD_STOP: begin
                if (i_state.phase == gvps_pkg::PH_RUN) begin
                    o_state.mark_tick = i_tick;
                    o_state.phase     = gvps_pkg::PH_OPEN;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/gas_valve_purge_sequencer_top.sv =====
`default_nettype none

// Channel     | Direction | Handshake                      | Contents
// ------------+-----------+--------------------------------+-------------------------------
// s_axis      | in        | s_axis_tvalid / s_axis_tready  | one command per transaction
// m_axis      | out       | m_axis_tvalid / m_axis_tready  | one result per command
// cfg         | in        | i_cfg_valid / o_cfg_ready      | register index + write data
//
// One command per cycle sustained while the output is not stalled. A command
// is held in the input register, is evaluated there against the sequencer
// state, and the result is then registered in the output register.
// The sequencer state moves on only as the result is registered, so the
// next command always sees the state left by the one before it.
// Reset (synchronous, active low) returns to idle, valve closed, on-time 0,
// output assigned. A stalled output holds the result; the input register
// still refills behind it and then stalls in turn. cfg is always ready.

module gas_valve_purge_sequencer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [0] gas_selected, [16:1] tick_now, [32:17] start_delay, [39:33] zero
    input  wire logic [39:0] s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]  s_axis_tuser,

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [0] valve_open, [1] delay_pending, [3:2] phase, [7:4] zero
    output logic [7:0]       m_axis_tdata,

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    // 0 on_time, 1 output_assigned
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    gvps_pkg::t_cfg   w_cfg;
    gvps_pkg::t_state r_state;
    gvps_pkg::t_state n_state;

    // input register
    logic        r_in_valid;
    logic [1:0]  r_in_cmd;
    logic        r_in_gas;
    logic [15:0] r_in_tick;
    logic [15:0] r_in_delay;

    // output register
    logic        r_out_valid;
    logic [3:0]  r_out_data;

    logic        w_out_free;
    logic        w_adv;

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_adv         = r_in_valid && w_out_free;
    assign s_axis_tready = !r_in_valid || w_adv;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_data};

    gvps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    gvps_step u_step (
        .i_state (r_state),
        .i_cfg   (w_cfg),
        .i_cmd   (r_in_cmd),
        .i_gas   (r_in_gas),
        .i_tick  (r_in_tick),
        .i_delay (r_in_delay),
        .o_state (n_state)
    );

    // input stage: load on every accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= s_axis_tuser;
            r_in_gas   <= s_axis_tdata[0];
            r_in_tick  <= s_axis_tdata[16:1];
            r_in_delay <= s_axis_tdata[32:17];
        end
    end

    // sequencer state commits together with the result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase      <= gvps_pkg::PH_IDLE;
            r_state.mark_tick  <= 16'd0;
            r_state.held_delay <= 16'd0;
            r_state.valve      <= 1'b0;
            r_state.pending    <= 1'b0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= {gvps_pkg::phase_code(n_state.phase), n_state.pending, n_state.valve};
        end
    end

endmodule

`default_nettype wire
